@@ hw/rtl/fnvd_pkg.sv @@
// fnvd_pkg: shared widths, word types and register indexes for the face
// normal view dot block. No dependencies.
`default_nettype none
package fnvd_pkg;

    localparam int COORD_W    = 32;
    localparam int CFG_W      = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int UNIT_SHIFT = 30;

    localparam int EDGE_W  = COORD_W + 1;
    localparam int PROD_W  = 2 * EDGE_W;
    localparam int CROSS_W = PROD_W + 1;
    localparam int MAG_W   = PROD_W;
    localparam int POS_W   = $clog2(MAG_W);
    localparam int M_W     = UNIT_SHIFT + 1;
    localparam int SQ_W    = 2 * M_W + 2;
    localparam int ROOT_W  = SQ_W / 2;
    localparam int Q_W     = UNIT_SHIFT + 1;
    localparam int N_W     = Q_W + 1;
    localparam int DOT_W   = 64;

    localparam int FRONT_STAGES = 8;
    localparam int SQRT_STAGES  = ROOT_W;
    localparam int DIV_STAGES   = Q_W;
    localparam int LATENCY      = FRONT_STAGES + SQRT_STAGES + DIV_STAGES + 3;

    localparam logic [CFG_IDX_W-1:0] CFG_VIEW_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VIEW_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VIEW_Z = 2'd2;

    localparam logic [CFG_W-1:0] VIEW_Z_RESET = 32'h0001_0000;

    typedef struct packed {
        logic signed [COORD_W-1:0] a_x;
        logic signed [COORD_W-1:0] a_y;
        logic signed [COORD_W-1:0] a_z;
        logic signed [COORD_W-1:0] b_x;
        logic signed [COORD_W-1:0] b_y;
        logic signed [COORD_W-1:0] b_z;
        logic signed [COORD_W-1:0] c_x;
        logic signed [COORD_W-1:0] c_y;
        logic signed [COORD_W-1:0] c_z;
    } face_t;

    typedef struct packed {
        logic signed [31:0] visibility;
        logic               degenerate;
    } result_t;

    typedef struct packed {
        logic [2:0] neg;
        logic       degen;
    } side_t;

endpackage
`default_nettype wire

@@ hw/rtl/face_normal_view_dot.sv @@
// face_normal_view_dot: top level, cross product, normalization and view dot.
// Depends on fnvd_pkg, fnvd_sqrt and fnvd_div.
//
// One face word is taken every clock (busy stays low) and its result word
// appears on result with done high for one cycle, in order. The square root
// and divider pipelines each resolve one bit per stage. Results cannot be
// held off. The view vector registers are read live and should be written
// only while no face is in flight.
`default_nettype none
module face_normal_view_dot
    import fnvd_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire face_t                face,
    output logic                      done,
    output result_t                   result,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_idx,
    input  wire logic [CFG_W-1:0]     cfg_data
);

    logic [CFG_W-1:0] view_x_reg, view_y_reg, view_z_reg;
    logic [LATENCY-1:0] vld_reg, vld_next;

    logic signed [EDGE_W-1:0]  e1_reg [3];
    logic signed [EDGE_W-1:0]  e2_reg [3];
    logic signed [PROD_W-1:0]  p_reg  [6];
    logic signed [CROSS_W-1:0] c_reg  [3];
    logic [MAG_W-1:0]          mag4_reg [3];
    side_t                     side4_reg;
    logic [MAG_W-1:0]          mag5_reg [3];
    logic [POS_W-1:0]          pos_reg;
    side_t                     side5_reg;
    logic [M_W-1:0]            m6_reg [3];
    side_t                     side6_reg;
    logic [2*M_W-1:0]          sq_reg [3];
    logic [M_W-1:0]            m7_reg [3];
    side_t                     side7_reg;
    logic [SQ_W-1:0]           sum_reg;
    logic [M_W-1:0]            m8_reg [3];
    side_t                     side8_reg;

    logic [M_W-1:0]            m_dly_reg    [SQRT_STAGES][3];
    side_t                     side_dly_reg [SQRT_STAGES];
    side_t                     sidd_dly_reg [DIV_STAGES];

    logic [ROOT_W-1:0]         len;
    logic [Q_W-1:0]            quot [3];
    logic signed [DOT_W-1:0]   dp_reg [3];
    logic                      degen_dp_reg;
    logic signed [DOT_W-1:0]   t_reg;
    logic                      degen_t_reg;
    result_t                   result_reg;

    logic [POS_W-1:0]          pos_next;
    logic [MAG_W-1:0]          orv_next;
    logic signed [DOT_W-1:0]   shr;

    assign busy = 1'b0;

    always_comb
    begin
        vld_next = {vld_reg[LATENCY-2:0], start & ~busy};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            view_x_reg <= '0;
            view_y_reg <= '0;
            view_z_reg <= VIEW_Z_RESET;
        end
        else
        begin
            vld_reg <= vld_next;
            if (cfg_we)
            begin
                case (cfg_idx)
                    CFG_VIEW_X: view_x_reg <= cfg_data;
                    CFG_VIEW_Y: view_y_reg <= cfg_data;
                    CFG_VIEW_Z: view_z_reg <= cfg_data;
                    default:    ;
                endcase
            end
        end
    end

    always_comb
    begin
        orv_next = mag4_reg[0] | mag4_reg[1] | mag4_reg[2];
        pos_next = '0;
        for (int i = 0; i < MAG_W; i++)
        begin
            if (orv_next[i])
                pos_next = POS_W'(i);
        end
    end

    always_ff @(posedge clk)
    begin
        e1_reg[0] <= EDGE_W'(face.b_x) - EDGE_W'(face.a_x);
        e1_reg[1] <= EDGE_W'(face.b_y) - EDGE_W'(face.a_y);
        e1_reg[2] <= EDGE_W'(face.b_z) - EDGE_W'(face.a_z);
        e2_reg[0] <= EDGE_W'(face.c_x) - EDGE_W'(face.a_x);
        e2_reg[1] <= EDGE_W'(face.c_y) - EDGE_W'(face.a_y);
        e2_reg[2] <= EDGE_W'(face.c_z) - EDGE_W'(face.a_z);

        p_reg[0] <= e1_reg[1] * e2_reg[2];
        p_reg[1] <= e1_reg[2] * e2_reg[1];
        p_reg[2] <= e1_reg[2] * e2_reg[0];
        p_reg[3] <= e1_reg[0] * e2_reg[2];
        p_reg[4] <= e1_reg[0] * e2_reg[1];
        p_reg[5] <= e1_reg[1] * e2_reg[0];

        for (int i = 0; i < 3; i++)
        begin
            c_reg[i] <= CROSS_W'(p_reg[2*i]) - CROSS_W'(p_reg[2*i+1]);
            side4_reg.neg[i] <= c_reg[i][CROSS_W-1];
            mag4_reg[i] <= c_reg[i][CROSS_W-1] ? MAG_W'(-c_reg[i]) : MAG_W'(c_reg[i]);
        end
        side4_reg.degen <= 1'b0;

        pos_reg         <= pos_next;
        mag5_reg        <= mag4_reg;
        side5_reg.neg   <= side4_reg.neg;
        side5_reg.degen <= (orv_next == '0);

        side6_reg <= side5_reg;
        for (int i = 0; i < 3; i++)
        begin
            if (32'(pos_reg) > UNIT_SHIFT)
                m6_reg[i] <= M_W'(mag5_reg[i] >> (32'(pos_reg) - UNIT_SHIFT));
            else
                m6_reg[i] <= M_W'(mag5_reg[i] << (UNIT_SHIFT - 32'(pos_reg)));
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
            sq_reg[i] <= m6_reg[i] * m6_reg[i];
        m7_reg    <= m6_reg;
        side7_reg <= side6_reg;

        sum_reg   <= SQ_W'(sq_reg[0]) + SQ_W'(sq_reg[1]) + SQ_W'(sq_reg[2]);
        m8_reg    <= m7_reg;
        side8_reg <= side7_reg;

        m_dly_reg[0]    <= m8_reg;
        side_dly_reg[0] <= side8_reg;
        for (int k = 1; k < SQRT_STAGES; k++)
        begin
            m_dly_reg[k]    <= m_dly_reg[k-1];
            side_dly_reg[k] <= side_dly_reg[k-1];
        end

        sidd_dly_reg[0] <= side_dly_reg[SQRT_STAGES-1];
        for (int k = 1; k < DIV_STAGES; k++)
            sidd_dly_reg[k] <= sidd_dly_reg[k-1];
    end

    fnvd_sqrt u_sqrt (
        .clk      (clk),
        .radicand (sum_reg),
        .root     (len)
    );

    for (genvar i = 0; i < 3; i++) begin : g_div
        fnvd_div u_div (
            .clk  (clk),
            .m    (m_dly_reg[SQRT_STAGES-1][i]),
            .len  (len),
            .quot (quot[i])
        );
    end

    always_comb
    begin
        shr = (t_reg + DOT_W'(64'sd1 <<< (UNIT_SHIFT - 1))) >>> UNIT_SHIFT;
    end

    always_ff @(posedge clk)
    begin
        dp_reg[0] <= $signed(sidd_dly_reg[DIV_STAGES-1].neg[0] ? N_W'(0) - N_W'(quot[0])
                                                                : N_W'(quot[0]))
                     * $signed(view_x_reg);
        dp_reg[1] <= $signed(sidd_dly_reg[DIV_STAGES-1].neg[1] ? N_W'(0) - N_W'(quot[1])
                                                                : N_W'(quot[1]))
                     * $signed(view_y_reg);
        dp_reg[2] <= $signed(sidd_dly_reg[DIV_STAGES-1].neg[2] ? N_W'(0) - N_W'(quot[2])
                                                                : N_W'(quot[2]))
                     * $signed(view_z_reg);
        degen_dp_reg <= sidd_dly_reg[DIV_STAGES-1].degen;

        t_reg       <= dp_reg[0] + dp_reg[1] + dp_reg[2];
        degen_t_reg <= degen_dp_reg;

        result_reg.degenerate <= degen_t_reg;
        if (degen_t_reg)
            result_reg.visibility <= '0;
        else if (shr > 64'sd2147483647)
            result_reg.visibility <= 32'sh7fff_ffff;
        else if (shr < -64'sd2147483648)
            result_reg.visibility <= 32'sh8000_0000;
        else
            result_reg.visibility <= shr[31:0];
    end

    assign done   = vld_reg[LATENCY-1];
    assign result = result_reg;

    a_done_follows_start : assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LATENCY))
        else $error("done without a start word");

    a_degen_zero : assert property (@(posedge clk) disable iff (!rst_n)
        done && result.degenerate |-> result.visibility == '0)
        else $error("degenerate word with nonzero visibility");

    a_len_range : assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[FRONT_STAGES+SQRT_STAGES-1] && !side_dly_reg[SQRT_STAGES-1].degen
        |-> len[ROOT_W-1:ROOT_W-2] != 2'b00)
        else $error("normalized length below unit");

endmodule
`default_nettype wire

@@ hw/rtl/fnvd_sqrt.sv @@
// fnvd_sqrt: pipelined integer square root, one result bit per stage.
// Depends on fnvd_pkg.
`default_nettype none
module fnvd_sqrt
    import fnvd_pkg::*;
(
    input  wire logic              clk,
    input  wire logic [SQ_W-1:0]   radicand,
    output logic      [ROOT_W-1:0] root
);

    localparam int REM_W = ROOT_W + 2;

    logic [SQ_W-1:0]   x_reg    [SQRT_STAGES];
    logic [REM_W-1:0]  rem_reg  [SQRT_STAGES];
    logic [ROOT_W-1:0] root_reg [SQRT_STAGES];

    for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
        logic [SQ_W-1:0]    x_in;
        logic [REM_W-1:0]   rem_in;
        logic [ROOT_W-1:0]  root_in;
        logic [REM_W+1:0]   acc;
        logic [REM_W+1:0]   trial;
        logic [REM_W+1:0]   diff;

        if (k == 0) begin : g_first
            assign x_in    = radicand;
            assign rem_in  = '0;
            assign root_in = '0;
        end else begin : g_next
            assign x_in    = x_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
        end

        always_comb
        begin
            acc   = {rem_in, x_in[SQ_W-1 -: 2]};
            trial = (REM_W+2)'({root_in, 2'b01});
            diff  = acc - trial;
        end

        always_ff @(posedge clk)
        begin
            x_reg[k] <= x_in << 2;
            if (acc >= trial)
            begin
                rem_reg[k]  <= diff[REM_W-1:0];
                root_reg[k] <= {root_in[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg[k]  <= acc[REM_W-1:0];
                root_reg[k] <= {root_in[ROOT_W-2:0], 1'b0};
            end
        end
    end

    assign root = root_reg[SQRT_STAGES-1];

endmodule
`default_nettype wire

@@ hw/rtl/fnvd_div.sv @@
// fnvd_div: pipelined restoring divider, (m << UNIT_SHIFT) / len, one quotient
// bit per stage. Depends on fnvd_pkg.
`default_nettype none
module fnvd_div
    import fnvd_pkg::*;
(
    input  wire logic              clk,
    input  wire logic [M_W-1:0]    m,
    input  wire logic [ROOT_W-1:0] len,
    output logic      [Q_W-1:0]    quot
);

    logic [ROOT_W-1:0] rem_reg [DIV_STAGES];
    logic [ROOT_W-1:0] len_reg [DIV_STAGES];
    logic [Q_W-1:0]    q_reg   [DIV_STAGES];

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
        logic [ROOT_W-1:0] rem_in;
        logic [ROOT_W-1:0] len_in;
        logic [Q_W-1:0]    q_in;
        logic              bit_in;
        logic [ROOT_W:0]   acc;
        logic [ROOT_W:0]   diff;

        if (k == 0) begin : g_first
            assign rem_in = ROOT_W'(m[M_W-1:1]);
            assign len_in = len;
            assign q_in   = '0;
            assign bit_in = m[0];
        end else begin : g_next
            assign rem_in = rem_reg[k-1];
            assign len_in = len_reg[k-1];
            assign q_in   = q_reg[k-1];
            assign bit_in = 1'b0;
        end

        always_comb
        begin
            acc  = {rem_in, bit_in};
            diff = acc - {1'b0, len_in};
        end

        always_ff @(posedge clk)
        begin
            len_reg[k] <= len_in;
            if (acc >= {1'b0, len_in})
            begin
                rem_reg[k] <= diff[ROOT_W-1:0];
                q_reg[k]   <= {q_in[Q_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg[k] <= acc[ROOT_W-1:0];
                q_reg[k]   <= {q_in[Q_W-2:0], 1'b0};
            end
        end
    end

    assign quot = q_reg[DIV_STAGES-1];

endmodule
`default_nettype wire

@@ tb/testbench.sv @@
// testbench: self-checking bench for face_normal_view_dot, a class that predicts
// each face's visibility word and checks results in order. Depends on fnvd_pkg
// and the face_normal_view_dot RTL.
module testbench;
    import fnvd_pkg::*;

    class visibility_board;
        logic [CFG_W-1:0] view [3];
        result_t          pending [$];

        function void set_view(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            if (idx == CFG_VIEW_X)
                view[0] = val;
            else if (idx == CFG_VIEW_Y)
                view[1] = val;
            else if (idx == CFG_VIEW_Z)
                view[2] = val;
        endfunction

        function logic [63:0] root_floor(logic [63:0] x);
            logic [63:0] r;
            logic [63:0] b;
            r = 0;
            b = 64'd1 << 62;
            while (b > x)
                b = b >> 2;
            while (b != 0) begin
                if (x >= r + b) begin
                    x = x - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
            return r;
        endfunction

        function result_t visibility_of(face_t f);
            logic signed [127:0] v [9];
            logic signed [127:0] e1 [3];
            logic signed [127:0] e2 [3];
            logic signed [127:0] c [3];
            logic [127:0]        mg [3];
            logic [127:0]        orv;
            logic [63:0]         m [3];
            logic [63:0]         sum;
            logic [63:0]         len;
            longint              n [3];
            longint              t;
            longint              r;
            int                  top;
            result_t             res;
            v[0] = f.a_x; v[1] = f.a_y; v[2] = f.a_z;
            v[3] = f.b_x; v[4] = f.b_y; v[5] = f.b_z;
            v[6] = f.c_x; v[7] = f.c_y; v[8] = f.c_z;
            for (int i = 0; i < 3; i++) begin
                e1[i] = v[3 + i] - v[i];
                e2[i] = v[6 + i] - v[i];
            end
            c[0] = e1[1] * e2[2] - e1[2] * e2[1];
            c[1] = e1[2] * e2[0] - e1[0] * e2[2];
            c[2] = e1[0] * e2[1] - e1[1] * e2[0];
            orv = 0;
            for (int i = 0; i < 3; i++) begin
                mg[i] = (c[i] < 0) ? -c[i] : c[i];
                orv = orv | mg[i];
            end
            res.visibility = 0;
            res.degenerate = 1'b1;
            if (orv == 0)
                return res;
            top = 0;
            for (int i = 0; i < 128; i++)
                if (orv[i])
                    top = i;
            sum = 0;
            for (int i = 0; i < 3; i++) begin
                if (top > UNIT_SHIFT)
                    m[i] = 64'(mg[i] >> (top - UNIT_SHIFT));
                else
                    m[i] = 64'(mg[i] << (UNIT_SHIFT - top));
                sum = sum + m[i] * m[i];
            end
            len = root_floor(sum);
            for (int i = 0; i < 3; i++) begin
                n[i] = longint'((m[i] << UNIT_SHIFT) / len);
                if (c[i] < 0)
                    n[i] = -n[i];
            end
            t = n[0] * longint'($signed(view[0])) + n[1] * longint'($signed(view[1]))
                + n[2] * longint'($signed(view[2]));
            r = (t + (longint'(1) << (UNIT_SHIFT - 1))) >>> UNIT_SHIFT;
            if (r > 64'sd2147483647)
                r = 64'sd2147483647;
            if (r < -64'sd2147483648)
                r = -64'sd2147483648;
            res.visibility = r[31:0];
            res.degenerate = 1'b0;
            return res;
        endfunction

        function void note_face(face_t f);
            pending.push_back(visibility_of(f));
        endfunction

        function string check_result(result_t got);
            result_t want;
            if (pending.size() == 0)
                return $sformatf("unexpected result vis=%0d degen=%0b",
                                 got.visibility, got.degenerate);
            want = pending.pop_front();
            if (got.visibility !== want.visibility || got.degenerate !== want.degenerate)
                return $sformatf("vis=%0d degen=%0b, want vis=%0d degen=%0b",
                                 got.visibility, got.degenerate,
                                 want.visibility, want.degenerate);
            return "";
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    face_t                face;
    logic                 done;
    result_t              result;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_W-1:0]     cfg_data;

    visibility_board board;
    int              errors;
    bit              idle_on;

    face_normal_view_dot uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .face     (face),
        .done     (done),
        .result   (result),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    task automatic report(string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        errors++;
    endtask

    always @(posedge clk)
    begin
        string msg;
        if (rst_n && done) begin
            msg = board.check_result(result);
            if (msg != "")
                report(msg);
        end
    end

    task automatic send_face(face_t f);
        int gap;
        gap = idle_on ? $urandom_range(0, 11) : 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        face  <= f;
        do
            @(posedge clk);
        while (busy);
        board.note_face(f);
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic write_view(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge clk);
        board.set_view(idx, val);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [31:0] pick_coord(int mode);
        case (mode)
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 8191)) - 4096) <<< 12;
            2: return $urandom_range(0, 15) < 8 ? 32'h8000_0000 : 32'h7fff_ffff;
            default: return 32'($signed($urandom_range(0, 200)) - 100);
        endcase
    endfunction

    function automatic face_t random_face();
        face_t f;
        int    mode;
        int    k;
        mode = $urandom_range(0, 3);
        f.a_x = pick_coord(mode); f.a_y = pick_coord(mode); f.a_z = pick_coord(mode);
        f.b_x = pick_coord(mode); f.b_y = pick_coord(mode); f.b_z = pick_coord(mode);
        f.c_x = pick_coord(mode); f.c_y = pick_coord(mode); f.c_z = pick_coord(mode);
        case ($urandom_range(0, 15))
            0: begin
                f.c_x = f.a_x; f.c_y = f.a_y; f.c_z = f.a_z;
            end
            1: begin
                k = $urandom_range(0, 6) - 3;
                f.c_x = f.a_x + k * (f.b_x - f.a_x);
                f.c_y = f.a_y + k * (f.b_y - f.a_y);
                f.c_z = f.a_z + k * (f.b_z - f.a_z);
            end
            default: ;
        endcase
        return f;
    endfunction

    task automatic directed_faces();
        face_t f;
        f = '0;
        send_face(f);
        f = '{0, 0, 0, 32'h10000, 0, 0, 0, 32'h10000, 0};
        send_face(f);
        f = '{0, 0, 0, 0, 32'h10000, 0, 32'h10000, 0, 0};
        send_face(f);
        f = '{0, 0, 0, 32'h10000, 32'h10000, 32'h10000, 32'h20000, 32'h20000, 32'h20000};
        send_face(f);
        f = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
              32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000};
        send_face(f);
        f = '{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
              32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000};
        send_face(f);
        f = '{32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
              32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff};
        send_face(f);
        f = '{0, 0, 0, 1, 0, 0, 0, 1, 0};
        send_face(f);
        f = '{0, 0, 0, 1, 1, 0, 0, 1, 1};
        send_face(f);
        f = '{32'hffff_ffff, 0, 0, 0, 32'hffff_ffff, 0, 0, 0, 32'hffff_ffff};
        send_face(f);
        f = '{5, 7, 9, 5, 7, 9, 1, 2, 3};
        send_face(f);
        f = '{0, 0, 0, 32'h7fff_ffff, 1, 0, 1, 32'h7fff_ffff, 0};
        send_face(f);
        f = '{0, 0, 0, 3, 0, 0, 0, 32'h7fff_0000, 0};
        send_face(f);
    endtask

    task automatic random_phase(int count);
        for (int i = 0; i < count; i++) begin
            if (i % 50 == 0)
                idle_on = $urandom_range(0, 3) != 0;
            send_face(random_face());
        end
    endtask

    initial
    begin
        board     = new();
        board.view[0] = 0;
        board.view[1] = 0;
        board.view[2] = VIEW_Z_RESET;
        errors   = 0;
        idle_on  = 1'b1;
        rst_n    = 1'b0;
        start    = 1'b0;
        face     = '0;
        cfg_we   = 1'b0;
        cfg_idx  = '0;
        cfg_data = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_faces();
        random_phase(150);
        drain();

        write_view(CFG_VIEW_X, 32'h7fff_ffff);
        write_view(CFG_VIEW_Y, 32'h7fff_ffff);
        write_view(CFG_VIEW_Z, 32'h7fff_ffff);
        directed_faces();
        random_phase(250);
        drain();

        write_view(CFG_VIEW_X, 32'h8000_0000);
        write_view(CFG_VIEW_Y, 32'h8000_0000);
        write_view(CFG_VIEW_Z, 32'h8000_0000);
        write_view(2'd3, 32'h1234_5678);
        directed_faces();
        random_phase(250);
        drain();

        write_view(CFG_VIEW_X, 32'h8000_0000);
        write_view(CFG_VIEW_Y, 32'h7fff_ffff);
        write_view(CFG_VIEW_Z, 0);
        random_phase(200);
        drain();

        for (int p = 0; p < 5; p++) begin
            write_view(CFG_VIEW_X, $urandom());
            write_view(CFG_VIEW_Y, $urandom());
            write_view(CFG_VIEW_Z, $urandom());
            random_phase(200);
            drain();
        end

        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end
endmodule

@@ files.f @@
hw/rtl/fnvd_pkg.sv
hw/rtl/fnvd_sqrt.sv
hw/rtl/fnvd_div.sv
hw/rtl/face_normal_view_dot.sv
tb/testbench.sv
